>>> hw/rtl/gra_pkg.sv
// package: constants, types and the sequencer state encoding for the rectangle allocator
package gra_pkg;
  localparam int MAX_RECTS  = 64;
  localparam int COORD_BITS = 13;
  localparam int IDX_BITS   = $clog2(MAX_RECTS);
  localparam int CNT_BITS   = $clog2(MAX_RECTS + 1);
  localparam int DIM_BITS   = 13;
  localparam int GUARD_BITS = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int REG_ATLAS_W = 0;
  localparam int REG_ATLAS_H = 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_SPLIT,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   item_width;
    logic [DIM_BITS-1:0]   item_height;
    logic [GUARD_BITS-1:0] guard_x;
    logic [GUARD_BITS-1:0] guard_y;
    logic                  kind;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COORD_BITS-1:0] place_x;
    logic [COORD_BITS-1:0] place_y;
    logic [CNT_BITS-1:0]   free_count;
  } rsp_t;
endpackage

>>> hw/rtl/gra_if.sv
// interfaces: request, response and configuration channels
interface gra_req_if import gra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [DIM_BITS-1:0]   item_width;
  logic [DIM_BITS-1:0]   item_height;
  logic [GUARD_BITS-1:0] guard_x;
  logic [GUARD_BITS-1:0] guard_y;
  modport source (output valid, kind, item_width, item_height, guard_x, guard_y,
                  input ready);
  modport sink (input valid, kind, item_width, item_height, guard_x, guard_y,
                output ready);
endinterface

interface gra_rsp_if import gra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [COORD_BITS-1:0] place_x;
  logic [COORD_BITS-1:0] place_y;
  logic [CNT_BITS-1:0]   free_count;
  modport source (output valid, status, place_x, place_y, free_count, input ready);
  modport sink (input valid, status, place_x, place_y, free_count, output ready);
endinterface

interface gra_cfg_if import gra_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [12:0]             data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/guillotine_rect_allocator_top.sv
// top level: guillotine free-rectangle allocator with a one-read, one-write rectangle memory
// sequence from request accept to response valid: a clear goes straight to done; an allocate
// runs scan (ends early on an exact fit), fetch, split if a fit was found, move when the entry
// is used up, then done; one request at a time, a new one is taken only in idle
// reset: synchronous, atlas 1024x1024, entry 0 = full atlas written in the first idle cycle
// response register lets the next request enter while a result waits; done stalls until it drains
module guillotine_rect_allocator_top import gra_pkg::*; (
  input logic clk,
  input logic rst,
  gra_req_if.sink   req,
  gra_rsp_if.source rsp,
  gra_cfg_if.sink   cfg
);

  // rectangle memory, registered read
  box_t mem [MAX_RECTS];
  box_t rd_data;
  logic [IDX_BITS-1:0] rd_addr;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  box_t                wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  logic [12:0] atlas_w;
  logic [12:0] atlas_h;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= 13'd1024;
      atlas_h <= 13'd1024;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IDX_BITS'(REG_ATLAS_W): atlas_w <= cfg.data;
        CFG_IDX_BITS'(REG_ATLAS_H): atlas_h <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t state, state_next;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] scan_idx;     // address issued this cycle
  logic                scan_vld;     // rd_data holds entry scan_chk
  logic [IDX_BITS-1:0] scan_chk;
  logic                found;
  logic [IDX_BITS-1:0] best;
  logic [COORD_BITS-1:0] best_left;
  logic [COORD_BITS:0] gw, gh;        // gross size, may exceed coord range
  logic [GUARD_BITS-1:0] gx, gy;
  status_t             res_status;   // working result, copied to rsp_q in done
  logic [COORD_BITS-1:0] res_x, res_y;
  logic                rsp_full;
  rsp_t                rsp_q;
  logic                boot;         // write entry 0 after reset
  logic                pend;         // second piece waits for the append write in done
  box_t                pend_box;

  // current entry evaluation
  logic [COORD_BITS-1:0] rw, rh;
  logic                fits;
  logic [COORD_BITS-1:0] dx, dy, m;
  always_comb begin
    rw = rd_data.x1 - rd_data.x0;
    rh = rd_data.y1 - rd_data.y0;
    fits = (rd_data.x1 >= rd_data.x0) && (rd_data.y1 >= rd_data.y0) &&
           ({1'b0, rw} >= gw) && ({1'b0, rh} >= gh);
    dx = rw - gw[COORD_BITS-1:0];
    dy = rh - gh[COORD_BITS-1:0];
    m  = (dx < dy) ? dx : dy;
  end

  // split of the chosen rectangle (rd_data in S_SPLIT)
  box_t pa, pb;
  logic ea, eb;
  always_comb begin
    if (dx > dy) begin
      pa = '{x0: rd_data.x0 + gw[COORD_BITS-1:0], y0: rd_data.y0,
             x1: rd_data.x1, y1: rd_data.y1};
      pb = '{x0: rd_data.x0, y0: rd_data.y0 + gh[COORD_BITS-1:0],
             x1: rd_data.x0 + gw[COORD_BITS-1:0], y1: rd_data.y1};
    end else begin
      pa = '{x0: rd_data.x0, y0: rd_data.y0 + gh[COORD_BITS-1:0],
             x1: rd_data.x1, y1: rd_data.y1};
      pb = '{x0: rd_data.x0 + gw[COORD_BITS-1:0], y0: rd_data.y0,
             x1: rd_data.x1, y1: rd_data.y0 + gh[COORD_BITS-1:0]};
    end
    ea = (pa.x1 <= pa.x0) || (pa.y1 <= pa.y0);
    eb = (pb.x1 <= pb.x0) || (pb.y1 <= pb.y0);
  end

  wire scan_last = (scan_idx == count);
  assign req.ready = (state == S_IDLE) && !boot;
  wire acc = req.valid && req.ready;
  wire rsp_take = rsp.valid && rsp.ready;
  // done hands its result over once the response register is free
  wire rsp_load = (state == S_DONE) && (!rsp_full || rsp_take);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc) state_next = (req.kind == KIND_CLEAR) ? S_DONE : S_SCAN;
      S_SCAN: begin
        if ((scan_vld && fits && dx == '0 && dy == '0) || scan_last) state_next = S_FETCH;
      end
      S_FETCH: state_next = found ? S_SPLIT : S_DONE;
      S_SPLIT: state_next = (ea && eb) ? S_MOVE : S_DONE;
      S_MOVE:  state_next = S_DONE;
      S_DONE:  state_next = rsp_load ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = scan_idx[IDX_BITS-1:0];
    wr_en   = 1'b0;
    wr_addr = best;
    wr_data = pa;
    case (state)
      S_IDLE: begin
        if (boot || (acc && req.kind == KIND_CLEAR)) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '{x0: '0, y0: '0, x1: atlas_w[COORD_BITS-1:0],
                      y1: atlas_h[COORD_BITS-1:0]};
        end
      end
      S_FETCH: rd_addr = best;
      S_SPLIT: begin
        rd_addr = IDX_BITS'(count - 1'b1);
        if (!(ea && eb) && !(!ea && !eb && count == CNT_BITS'(MAX_RECTS))) begin
          wr_en   = 1'b1;
          wr_addr = best;
          wr_data = ea ? pb : pa;
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = best;
        wr_data = rd_data;
      end
      S_DONE: begin
        // append of the second piece at the end of the table
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = count[IDX_BITS-1:0];
          wr_data = pend_box;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= CNT_BITS'(1);
      rsp_full <= 1'b0;
      boot     <= 1'b1;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      boot  <= 1'b0;
      if (rsp_load) rsp_full <= 1'b1;
      else if (rsp_take) rsp_full <= 1'b0;
      if (rsp_load) begin
        rsp_q <= '{status: res_status, place_x: res_x, place_y: res_y,
                   free_count: pend ? count + CNT_BITS'(1) : count};
      end
      case (state)
        S_IDLE: if (acc) begin
          gw <= (COORD_BITS+1)'(req.item_width) + (COORD_BITS+1)'({req.guard_x, 1'b0});
          gh <= (COORD_BITS+1)'(req.item_height) + (COORD_BITS+1)'({req.guard_y, 1'b0});
          gx <= req.guard_x;
          gy <= req.guard_y;
          scan_idx   <= '0;
          scan_vld   <= 1'b0;
          found      <= 1'b0;
          best_left  <= '1;
          res_status <= ST_OK;
          res_x      <= '0;
          res_y      <= '0;
          if (req.kind == KIND_CLEAR) count <= CNT_BITS'(1);
        end
        S_SCAN: begin
          if (scan_vld && fits && (!found || m < best_left || (dx == '0 && dy == '0))) begin
            found     <= 1'b1;
            best      <= scan_chk;
            best_left <= m;
          end
          scan_chk <= scan_idx[IDX_BITS-1:0];
          scan_vld <= !scan_last;
          if (!scan_last) scan_idx <= scan_idx + CNT_BITS'(1);
        end
        S_FETCH: if (!found) res_status <= ST_NO_FIT;
        S_SPLIT: begin
          if (!ea && !eb && count == CNT_BITS'(MAX_RECTS)) begin
            res_status <= ST_FULL;
          end else begin
            res_x <= rd_data.x0 + COORD_BITS'(gx);
            res_y <= rd_data.y0 + COORD_BITS'(gy);
            if (ea && eb) count <= count - CNT_BITS'(1);
            if (!ea && !eb) begin
              pend     <= 1'b1;
              pend_box <= pb;
            end
          end
        end
        S_DONE: begin
          if (pend) begin
            pend  <= 1'b0;
            count <= count + CNT_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid      = rsp_full;
  assign rsp.status     = rsp_q.status;
  assign rsp.place_x    = rsp_q.place_x;
  assign rsp.place_y    = rsp_q.place_y;
  assign rsp.free_count = rsp_q.free_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_RECTS)) else $error("rect count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
endmodule

>>> test/tb_guillotine_rect_allocator_top.sv
// testbench for the guillotine rectangle allocator: directed and random requests against a predictor
module tb_guillotine_rect_allocator_top;
  import gra_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  gra_req_if req_ch ();
  gra_rsp_if rsp_ch ();
  gra_cfg_if cfg_ch ();

  guillotine_rect_allocator_top dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  // predictor state: own copy of the free table and the atlas registers
  box_t        pred_rects [MAX_RECTS];
  int unsigned pred_count;
  logic [12:0] pred_atlas_w;
  logic [12:0] pred_atlas_h;

  // expected responses, oldest first
  rsp_t placements_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  idle_free = 1'b0;     // long stretch with no idling
  int  hold_off = 0;         // receiver hold-off in cycles
  localparam int CYCLE_LIMIT = 2000000;

  function automatic bit box_is_empty(box_t b);
    return (b.x1 <= b.x0) || (b.y1 <= b.y0);
  endfunction

  task automatic clear_pred_table();
    for (int i = 0; i < MAX_RECTS; i++) pred_rects[i] = '0;
    pred_rects[0].x1 = pred_atlas_w;
    pred_rects[0].y1 = pred_atlas_h;
    pred_count = 1;
  endtask

  // predict one response and update the predicted table
  task automatic predict_placement(req_t r);
    rsp_t        res;
    int unsigned gw, gh, best, best_left, rw, rh, dx, dy, m, n;
    box_t        cur, pa, pb;
    box_t        pieces [2];
    res = '0;
    if (r.kind == KIND_CLEAR) begin
      clear_pred_table();
    end else begin
      gw = r.item_width + 2 * r.guard_x;
      gh = r.item_height + 2 * r.guard_y;
      best = pred_count;
      best_left = 32'hffff_ffff;
      for (int i = 0; i < pred_count; i++) begin
        cur = pred_rects[i];
        if (cur.x1 < cur.x0 || cur.y1 < cur.y0) continue;
        rw = cur.x1 - cur.x0;
        rh = cur.y1 - cur.y0;
        if (rw < gw || rh < gh) continue;
        dx = rw - gw;
        dy = rh - gh;
        if (dx == 0 && dy == 0) begin
          best = i;
          break;
        end
        m = (dx < dy) ? dx : dy;
        if (m < best_left) begin
          best_left = m;
          best = i;
        end
      end
      if (best >= pred_count) begin
        res.status = ST_NO_FIT;
      end else begin
        cur = pred_rects[best];
        dx = (cur.x1 - cur.x0) - gw;
        dy = (cur.y1 - cur.y0) - gh;
        // split along the longer leftover
        if (dx > dy) begin
          pa.x0 = cur.x0 + gw; pa.y0 = cur.y0; pa.x1 = cur.x1; pa.y1 = cur.y1;
          pb.x0 = cur.x0; pb.y0 = cur.y0 + gh; pb.x1 = cur.x0 + gw; pb.y1 = cur.y1;
        end else begin
          pa.x0 = cur.x0; pa.y0 = cur.y0 + gh; pa.x1 = cur.x1; pa.y1 = cur.y1;
          pb.x0 = cur.x0 + gw; pb.y0 = cur.y0; pb.x1 = cur.x1; pb.y1 = cur.y0 + gh;
        end
        n = 0;
        if (!box_is_empty(pa)) begin pieces[n] = pa; n++; end
        if (!box_is_empty(pb)) begin pieces[n] = pb; n++; end
        if (n == 2 && pred_count >= MAX_RECTS) begin
          res.status = ST_FULL;
        end else begin
          if (n == 0) begin
            // exact use: last entry moves into the freed slot
            pred_count--;
            pred_rects[best] = pred_rects[pred_count];
            pred_rects[pred_count] = '0;
          end else begin
            pred_rects[best] = pieces[0];
            if (n == 2) begin
              pred_rects[pred_count] = pieces[1];
              pred_count++;
            end
          end
          res.status = ST_OK;
          res.place_x = cur.x0 + r.guard_x;
          res.place_y = cur.y0 + r.guard_y;
        end
      end
    end
    res.free_count = CNT_BITS'(pred_count);
    placements_due.insert(placements_due.size(), res);
  endtask

  function automatic bit idle_roll();
    return !idle_free && ($urandom_range(99) < 6);
  endfunction

  // send one request, with random idle gaps before it; valid stays up for the next one
  task automatic send_request(req_t r);
    while (idle_roll()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= r.kind;
    req_ch.item_width  <= r.item_width;
    req_ch.item_height <= r.item_height;
    req_ch.guard_x     <= r.guard_x;
    req_ch.guard_y     <= r.guard_y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_placement(r);
  endtask

  task automatic send_alloc(int w, int h, int gx, int gy);
    req_t r;
    r.kind = KIND_ALLOC;
    r.item_width = w; r.item_height = h; r.guard_x = gx; r.guard_y = gy;
    send_request(r);
  endtask

  task automatic send_clear();
    req_t r;
    r = '0;
    r.kind = KIND_CLEAR;
    r.item_width = $urandom; r.item_height = $urandom;
    r.guard_x = $urandom; r.guard_y = $urandom;
    send_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // register write, only while idle; the caller drops valid after the last one
  task automatic write_register(int idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ATLAS_W) pred_atlas_w = value;
    else pred_atlas_h = value;
  endtask

  task automatic set_atlas(int w, int h);
    drain();
    write_register(REG_ATLAS_W, w);
    write_register(REG_ATLAS_H, h);
    cfg_ch.valid <= 1'b0;
    send_clear();
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response at cycle %0d", cycle_count);
      end else begin
        exp_rsp = placements_due.pop_front();
        if (rsp_ch.status !== exp_rsp.status || rsp_ch.place_x !== exp_rsp.place_x ||
            rsp_ch.place_y !== exp_rsp.place_y ||
            rsp_ch.free_count !== exp_rsp.free_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d x=%0d y=%0d n=%0d got st=%0d x=%0d y=%0d n=%0d",
                     exp_rsp.status, exp_rsp.place_x, exp_rsp.place_y, exp_rsp.free_count,
                     rsp_ch.status, rsp_ch.place_x, rsp_ch.place_y, rsp_ch.free_count);
        end
      end
    end
  end

  // receiver ready: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !idle_roll();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("guillotine_rect_allocator_top regression: fail");
      $finish;
    end
  end

  // directed: extremes of fields, exact fit, both splits, no fit
  task automatic test_directed();
    send_alloc(0, 0, 0, 0);
    send_alloc(4096, 4096, 255, 255);
    send_alloc(8191, 8191, 255, 255);
    send_alloc(1024, 1024, 0, 0);       // exact fit empties the table
    send_alloc(1, 1, 0, 0);             // empty table never fits
    send_clear();
    send_alloc(100, 10, 3, 1);
    send_alloc(10, 100, 1, 3);
    send_alloc(1018, 10, 0, 0);
    send_alloc(0, 5, 7, 0);
    send_alloc(5, 0, 0, 7);
    send_alloc(8191, 1, 0, 0);
    send_clear();
  endtask

  // zero and maximal atlas sizes
  task automatic test_atlas_extremes();
    set_atlas(0, 0);
    send_alloc(0, 0, 0, 0);
    send_alloc(0, 0, 0, 0);
    set_atlas(8191, 1);
    send_alloc(8000, 1, 0, 0);
    send_alloc(191, 1, 0, 0);
    set_atlas(1, 4096);
    send_alloc(1, 4096, 0, 0);
    set_atlas(4096, 4096);
    send_alloc(4096, 4096, 0, 0);
  endtask

  // many small allocations to fill the table
  task automatic test_table_full();
    set_atlas(4096, 4096);
    for (int i = 0; i < 110; i++)
      send_alloc($urandom_range(40, 1), $urandom_range(40, 1), $urandom_range(2), 0);
  endtask

  task automatic random_alloc();
    int sel;
    sel = $urandom_range(99);
    if (sel < 2) send_clear();
    else if (sel < 80)
      send_alloc($urandom_range(120), $urandom_range(120), $urandom_range(4),
                 $urandom_range(4));
    else if (sel < 95)
      send_alloc($urandom_range(600), $urandom_range(600), $urandom_range(255),
                 $urandom_range(255));
    else send_alloc($urandom_range(8191), $urandom_range(8191), $urandom, $urandom);
  endtask

  task automatic test_random(int count, int aw, int ah);
    set_atlas(aw, ah);
    for (int i = 0; i < count; i++) random_alloc();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    drain();
    hold_off = 300;
    for (int i = 0; i < 20; i++) random_alloc();
  endtask

  task automatic test_no_idle();
    drain();
    idle_free = 1'b1;
    for (int i = 0; i < 200; i++) random_alloc();
    drain();
    idle_free = 1'b0;
  endtask

  initial begin
    req_ch.valid = 1'b0; req_ch.kind = KIND_CLEAR;
    req_ch.item_width = '0; req_ch.item_height = '0;
    req_ch.guard_x = '0; req_ch.guard_y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    pred_atlas_w = 13'd1024;
    pred_atlas_h = 13'd1024;
    clear_pred_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_atlas_extremes();
    test_table_full();
    test_random(500, 1024, 1024);
    test_backpressure();
    test_no_idle();
    test_random(300, 300, 2000);
    test_random(300, 8191, 8191);
    drain();
    if (mismatches == 0 && placements_due.size() == 0)
      $display("guillotine_rect_allocator_top regression: pass");
    else
      $display("guillotine_rect_allocator_top regression: fail");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/gra_pkg.sv
hw/rtl/gra_if.sv
hw/rtl/guillotine_rect_allocator_top.sv
test/tb_guillotine_rect_allocator_top.sv
